/* sv/s1sh_pkg.sv */
// shared types and constants of the sha-1 stream hash unit
package s1sh_pkg;

	localparam int WordW     = 32;
	localparam int NumWords  = 16;
	localparam int NumRounds = 80;
	localparam int RndW      = 7;
	localparam int FillW     = 6;
	localparam int TotalW    = 61;
	localparam int LenCntW   = 3;

	typedef logic [WordW-1:0] word_t;

	// five working or chaining words, a first
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} vars_t;

	// index NumWords-1 holds the first word of the block
	typedef logic [NumWords-1:0][WordW-1:0] block_t;

	typedef struct packed {
		logic start;
		logic init;
	} ctl_t;

	localparam vars_t H_INIT = '{
		a: 32'h67452301,
		b: 32'hEFCDAB89,
		c: 32'h98BADCFE,
		d: 32'h10325476,
		e: 32'hC3D2E1F0
	};

	localparam word_t K_CH  = 32'h5A827999;
	localparam word_t K_PA1 = 32'h6ED9EBA1;
	localparam word_t K_MAJ = 32'h8F1BBCDC;
	localparam word_t K_PA2 = 32'hCA62C1D6;

	localparam logic [RndW-1:0] RND_CH_END  = RndW'(20);
	localparam logic [RndW-1:0] RND_PA1_END = RndW'(40);
	localparam logic [RndW-1:0] RND_MAJ_END = RndW'(60);
	localparam logic [RndW-1:0] RND_LAST    = RndW'(NumRounds - 1);

	localparam logic [7:0]       PAD_MARK  = 8'h80;
	localparam logic [FillW-1:0] PAD_STOP  = FillW'(56);
	localparam logic [FillW-1:0] FILL_LAST = FillW'(63);
	localparam logic [LenCntW-1:0] LEN_LAST = LenCntW'(7);

endpackage

/* sv/sha1_stream_hash_unit.sv */
// sha-1 stream hash unit: byte packing, padding sequencer and digest register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  msg     | msg_valid | msg_stall | data_byte, has_byte, end_of_message
//  dig     | dig_valid | dig_stall | digest_word0 .. digest_word4
//
// a byte that does not complete a 64-byte block is taken without raising msg_stall
// a byte that completes a block holds msg_stall for the load, the 80 rounds
// through the single round unit, the chaining add and the handoff
// a closing request pads byte by byte to the end of the block (a second block
// when fewer than 9 bytes remain) and compresses; the digest register is loaded
// once any older digest is taken, and the next message may start while it waits
// arst_n clears control state and loads the initial chaining words
module sha1_stream_hash_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    msg_valid,
	output logic                    msg_stall,
	input  logic [7:0]              data_byte,
	input  logic                    has_byte,
	input  logic                    end_of_message,
	output logic                    dig_valid,
	input  logic                    dig_stall,
	output s1sh_pkg::word_t         digest_word0,
	output s1sh_pkg::word_t         digest_word1,
	output s1sh_pkg::word_t         digest_word2,
	output s1sh_pkg::word_t         digest_word3,
	output s1sh_pkg::word_t         digest_word4
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD_MARK,
		S_PAD_ZERO,
		S_PAD_LEN,
		S_HASH,
		S_EMIT
	} state_t;

	state_t                        state_q;
	state_t                        ret_q;
	state_t                        after;
	logic [s1sh_pkg::FillW-1:0]    fill_q;
	logic [s1sh_pkg::TotalW-1:0]   total_q;
	logic [s1sh_pkg::LenCntW-1:0]  len_cnt_q;
	s1sh_pkg::ctl_t                ctl_q;
	logic                          dig_vld_q;
	s1sh_pkg::block_t              blk_q;
	s1sh_pkg::vars_t               dig_q;
	s1sh_pkg::vars_t               chain;
	logic                          done;
	logic                          put_en;
	logic [7:0]                    put_byte;
	logic                          full;
	logic                          emit_go;
	logic [7:0][7:0]               len_field;

	s1sh_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_q),
		.blk    (blk_q),
		.chain  (chain),
		.done   (done)
	);

	// message length in bits, most significant byte at index 7
	assign len_field = {total_q, 3'b000};

	always_comb begin
		put_en   = 1'b0;
		put_byte = data_byte;
		after    = state_q;
		unique case (state_q)
			S_IDLE: begin
				put_en = msg_valid && has_byte;
				after  = (msg_valid && end_of_message) ? S_PAD_MARK : S_IDLE;
			end
			S_PAD_MARK: begin
				put_en   = 1'b1;
				put_byte = s1sh_pkg::PAD_MARK;
				after    = S_PAD_ZERO;
			end
			S_PAD_ZERO: begin
				put_en   = (fill_q != s1sh_pkg::PAD_STOP);
				put_byte = '0;
				after    = (fill_q == s1sh_pkg::PAD_STOP) ? S_PAD_LEN : S_PAD_ZERO;
			end
			S_PAD_LEN: begin
				put_en   = 1'b1;
				put_byte = len_field[~len_cnt_q];
				after    = (len_cnt_q == s1sh_pkg::LEN_LAST) ? S_EMIT : S_PAD_LEN;
			end
			S_HASH: after = S_HASH;
			S_EMIT: after = S_EMIT;
			default: after = S_IDLE;
		endcase
	end

	assign full    = put_en && (fill_q == s1sh_pkg::FILL_LAST);
	assign emit_go = (state_q == S_EMIT) && (!dig_vld_q || !dig_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			fill_q    <= '0;
			total_q   <= '0;
			len_cnt_q <= '0;
			ctl_q     <= '0;
			dig_vld_q <= 1'b0;
		end else begin
			ctl_q     <= '{start: full, init: emit_go};
			dig_vld_q <= emit_go || (dig_vld_q && dig_stall);
			if (put_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == S_IDLE && msg_valid && has_byte) begin
				total_q <= total_q + 1'b1;
			end
			if (state_q == S_PAD_LEN) begin
				len_cnt_q <= len_cnt_q + 1'b1;
			end
			unique case (state_q) inside
				S_IDLE, S_PAD_MARK, S_PAD_ZERO, S_PAD_LEN: begin
					if (full) begin
						state_q <= S_HASH;
						ret_q   <= after;
					end else begin
						state_q <= after;
					end
				end
				S_HASH: begin
					if (done) begin
						state_q <= ret_q;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						total_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// bytes shift in at the bottom, so the first byte ends up in the top word
	always_ff @(posedge clk) begin
		if (put_en) begin
			blk_q <= (blk_q << 8) | s1sh_pkg::block_t'(put_byte);
		end
		if (emit_go) begin
			dig_q <= chain;
		end
	end

	assign msg_stall    = (state_q != S_IDLE);
	assign dig_valid    = dig_vld_q;
	assign digest_word0 = dig_q.a;
	assign digest_word1 = dig_q.b;
	assign digest_word2 = dig_q.c;
	assign digest_word3 = dig_q.d;
	assign digest_word4 = dig_q.e;

endmodule

/* sv/s1sh_round.sv */
// one sha-1 round and the next message schedule word
module s1sh_round (
	input  s1sh_pkg::vars_t          cur,
	input  logic [s1sh_pkg::RndW-1:0] rnd,
	input  s1sh_pkg::word_t          w0,
	input  s1sh_pkg::word_t          w2,
	input  s1sh_pkg::word_t          w8,
	input  s1sh_pkg::word_t          w13,
	output s1sh_pkg::vars_t          nxt,
	output s1sh_pkg::word_t          w_new
);

	s1sh_pkg::word_t f;
	s1sh_pkg::word_t k;
	s1sh_pkg::word_t mix;

	always_comb begin
		if (rnd < s1sh_pkg::RND_CH_END) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = s1sh_pkg::K_CH;
		end else if (rnd < s1sh_pkg::RND_PA1_END) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = s1sh_pkg::K_PA1;
		end else if (rnd < s1sh_pkg::RND_MAJ_END) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = s1sh_pkg::K_MAJ;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = s1sh_pkg::K_PA2;
		end
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w0;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

	// w[t+16] from the window that starts at w[t]
	assign mix   = w13 ^ w8 ^ w2 ^ w0;
	assign w_new = {mix[30:0], mix[31]};

endmodule

/* sv/s1sh_compress.sv */
// sha-1 compression engine: 80 rounds through one shared round unit
module s1sh_compress (
	input  logic              clk,
	input  logic              arst_n,
	input  s1sh_pkg::ctl_t    ctl,
	input  s1sh_pkg::block_t  blk,
	output s1sh_pkg::vars_t   chain,
	output logic              done
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_RUN,
		C_ADD
	} cstate_t;

	cstate_t                   state_q;
	logic [s1sh_pkg::RndW-1:0] rnd_q;
	logic                      done_q;
	s1sh_pkg::vars_t           h_q;
	s1sh_pkg::vars_t           v_q;
	s1sh_pkg::word_t           w_q [s1sh_pkg::NumWords];
	s1sh_pkg::vars_t           v_nxt;
	s1sh_pkg::word_t           w_new;

	s1sh_round u_round (
		.cur   (v_q),
		.rnd   (rnd_q),
		.w0    (w_q[0]),
		.w2    (w_q[2]),
		.w8    (w_q[8]),
		.w13   (w_q[13]),
		.nxt   (v_nxt),
		.w_new (w_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
			h_q     <= s1sh_pkg::H_INIT;
		end else begin
			done_q <= (state_q == C_ADD);
			unique case (state_q)
				C_IDLE: begin
					if (ctl.init) begin
						h_q <= s1sh_pkg::H_INIT;
					end else if (ctl.start) begin
						rnd_q   <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == s1sh_pkg::RND_LAST) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					h_q.a   <= h_q.a + v_q.a;
					h_q.b   <= h_q.b + v_q.b;
					h_q.c   <= h_q.c + v_q.c;
					h_q.d   <= h_q.d + v_q.d;
					h_q.e   <= h_q.e + v_q.e;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// schedule window shifts by one word per round
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctl.start && !ctl.init) begin
			v_q <= h_q;
			for (int i = 0; i < s1sh_pkg::NumWords; i++) begin
				w_q[i] <= blk[4'(s1sh_pkg::NumWords - 1 - i)];
			end
		end else if (state_q == C_RUN) begin
			v_q <= v_nxt;
			for (int i = 0; i < s1sh_pkg::NumWords - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[s1sh_pkg::NumWords-1] <= w_new;
		end
	end

	assign chain = h_q;
	assign done  = done_q;

endmodule

/* sv/s1sh_chk.sv */
// port checker for the sha-1 stream hash unit and its bind
module s1sh_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            msg_valid,
	input logic            msg_stall,
	input logic            end_of_message,
	input logic            dig_valid,
	input logic            dig_stall,
	input s1sh_pkg::word_t digest_word0,
	input s1sh_pkg::word_t digest_word4
);

	// a stalled digest stays offered
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_stall |=> dig_valid)
		else $error("digest dropped while stalled");

	a_dig_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_stall |=> $stable(digest_word0) && $stable(digest_word4))
		else $error("digest changed while stalled");

	// closing a message always starts padding, so the input side goes busy
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall && end_of_message |=> msg_stall)
		else $error("no padding after end of message");

	// a new digest is only loaded while the input side is held off
	a_dig_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> $past(msg_stall))
		else $error("digest appeared without a finishing pass");

endmodule

bind sha1_stream_hash_unit s1sh_chk u_s1sh_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.msg_valid      (msg_valid),
	.msg_stall      (msg_stall),
	.end_of_message (end_of_message),
	.dig_valid      (dig_valid),
	.dig_stall      (dig_stall),
	.digest_word0   (digest_word0),
	.digest_word4   (digest_word4)
);
